// ===== rtl/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the sorted array set
// Holds the capacity and key width, the request action codes and the
// command that the controller broadcasts to the row of key cells.
// ----------------------------------------------------------------------------
package sas_pkg;

  // Sizing of the set.
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned COUNT_W    = $clog2(CAPACITY + 1);

  // The match flags are reduced in groups, one register per group.
  localparam int unsigned GROUP_SIZE = 32;
  localparam int unsigned N_GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [COUNT_W-1:0]         count_t;

  localparam count_t CAP_COUNT = count_t'(CAPACITY);

  // Request action codes. The unused code behaves as a lookup.
  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_REMOVE   = 2'd1;
  localparam logic [1:0] ACT_CONTAINS = 2'd2;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    key_t     key;
  } cell_cmd_t;

endpackage

// ===== rtl/sas_cell.sv =====
// ----------------------------------------------------------------------------
// sas_cell: one slot of the sorted key row
// Holds one key, compares it with the broadcast key and, on an insert or a
// delete, takes the key of its left or right neighbor.
// ----------------------------------------------------------------------------
module sas_cell import sas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      occupied_i,
  input  key_t      prev_key_i,
  input  logic      prev_lt_i,
  input  key_t      next_key_i,
  output key_t      key_o,
  output logic      lt_o,
  output logic      eq_o
);

  key_t key_q, key_d;
  logic lt_q;
  logic eq_q;

  // Cells at or past the insert or delete position move by one slot.
  // The cell whose left neighbor is still below the key takes the new key.
  always_comb begin
    key_d = key_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (!lt_q) begin
          key_d = prev_lt_i ? cmd_i.key : prev_key_i;
        end
      end
      CELL_DELETE: begin
        if (!lt_q) begin
          key_d = next_key_i;
        end
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Compare flags are only meaningful for slots that hold a key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.op == CELL_COMPARE) begin
      lt_q <= occupied_i && (key_q < cmd_i.key);
      eq_q <= occupied_i && (key_q == cmd_i.key);
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ===== rtl/sas_hit_tree.sv =====
// ----------------------------------------------------------------------------
// sas_hit_tree: first level of the match reduction
// ORs the per-cell match flags in fixed groups and registers one hit bit
// per group for the controller.
// ----------------------------------------------------------------------------
module sas_hit_tree import sas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CAPACITY-1:0] eq_i,
  output logic [N_GROUPS-1:0] group_hit_o
);

  logic [N_GROUPS-1:0] group_hit_q;
  logic [N_GROUPS-1:0] group_hit_d;

  // OR the members of each group; the last group may be partly filled.
  for (genvar g = 0; g < N_GROUPS; g++) begin : g_group
    always_comb begin
      group_hit_d[g] = 1'b0;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        if (g * GROUP_SIZE + m < CAPACITY) begin
          group_hit_d[g] = group_hit_d[g] | eq_i[g * GROUP_SIZE + m];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_hit_q <= '0;
    end else begin
      group_hit_q <= group_hit_d;
    end
  end

  assign group_hit_o = group_hit_q;

endmodule

// ===== rtl/sas_ctrl.sv =====
// ----------------------------------------------------------------------------
// sas_ctrl: request sequencer for the sorted array set
// Takes one request, steps the cell row through compare, reduction and
// update, keeps the key count and holds the result register.
// ----------------------------------------------------------------------------
module sas_ctrl import sas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  key_t                key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic                full_reject_o,
  output count_t              occupancy_o,
  input  logic [N_GROUPS-1:0] group_hit_i,
  output cell_cmd_t           cmd_o,
  output count_t              count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_DEC
  } state_e;

  state_e     state_q;
  logic [1:0] action_q;
  key_t       key_q;
  count_t     count_q;
  count_t     count_d;
  logic       out_valid_q;
  logic       found_q;
  logic       reject_q;
  count_t     occ_q;

  logic       hit;
  logic       full;
  logic       out_free;
  logic       do_insert;
  logic       do_delete;
  logic       reject;

  // Final level of the match reduction and the update decision.
  assign hit       = |group_hit_i;
  assign full      = (count_q == CAP_COUNT);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_insert = (action_q == ACT_ADD) && !hit && !full;
  assign reject    = (action_q == ACT_ADD) && !hit && full;
  assign do_delete = (action_q == ACT_REMOVE) && hit;

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + count_t'(1);
    end else if (do_delete) begin
      count_d = count_q - count_t'(1);
    end
  end

  // Command to the cell row.
  always_comb begin
    cmd_o.key = key_q;
    cmd_o.op  = CELL_HOLD;
    unique case (state_q)
      ST_CMP: cmd_o.op = CELL_COMPARE;
      ST_DEC: begin
        if (out_free && do_insert) begin
          cmd_o.op = CELL_INSERT;
        end else if (out_free && do_delete) begin
          cmd_o.op = CELL_DELETE;
        end
      end
      default: cmd_o.op = CELL_HOLD;
    endcase
  end

  // Sequencer, count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= ACT_CONTAINS;
      key_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      reject_q    <= 1'b0;
      occ_q       <= '0;
    end else begin
      // The result is reloaded when a request completes, else cleared once taken.
      if (state_q == ST_DEC && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            action_q <= action_i;
            key_q    <= key_i;
            state_q  <= ST_CMP;
          end
        end
        ST_CMP: state_q <= ST_RED;
        ST_RED: state_q <= ST_DEC;
        ST_DEC: begin
          if (out_free) begin
            count_q  <= count_d;
            found_q  <= hit;
            reject_q <= reject;
            occ_q    <= count_d;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign full_reject_o = reject_q;
  assign occupancy_o   = occ_q;
  assign count_o       = count_q;

endmodule

// ===== rtl/sorted_array_set.sv =====
// ----------------------------------------------------------------------------
// sorted_array_set: set of signed keys kept as an ascending row of cells
// Top level: cell row, match reduction and request sequencer.
// ----------------------------------------------------------------------------
// Each request (add, remove or lookup of one signed key) is registered at the
// edge that accepts it; then every cell compares its key with the request
// key, the per-cell match flags are reduced in registered groups, and the
// group hits are combined, the row is shifted by one slot where needed and
// the result register is loaded. The input is stalled from acceptance until
// the result is loaded, so no new request is taken before the last one
// completes, while a result may still wait in the output register; a result
// that is still held off when the next one completes stalls the sequencer in
// its last step. Keys stay sorted with no duplicates; an add of an absent key
// to a full set is refused and flagged.
module sorted_array_set import sas_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic [1:0] action_i,
  input  key_t   key_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output logic   found_o,
  output logic   full_reject_o,
  output count_t occupancy_o
);

  cell_cmd_t           cmd;
  count_t              count;
  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_occ;
  logic [N_GROUPS-1:0] group_hit;

  // Request sequencer and key count.
  sas_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .full_reject_o(full_reject_o),
    .occupancy_o  (occupancy_o),
    .group_hit_i  (group_hit),
    .cmd_o        (cmd),
    .count_o      (count)
  );

  // Row of cells; each neighbor pair is wired for the one-slot shifts.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t prev_key;
    logic prev_lt;
    key_t next_key;

    assign cell_occ[i] = (count_t'(i) < count);

    if (i == 0) begin : g_first
      assign prev_key = cmd.key;
      assign prev_lt  = 1'b1;
    end else begin : g_inner_prev
      assign prev_key = cell_key[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner_next
      assign next_key = cell_key[i+1];
    end

    sas_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .occupied_i(cell_occ[i]),
      .prev_key_i(prev_key),
      .prev_lt_i (prev_lt),
      .next_key_i(next_key),
      .key_o     (cell_key[i]),
      .lt_o      (cell_lt[i]),
      .eq_o      (cell_eq[i])
    );
  end

  // Grouped reduction of the match flags.
  sas_hit_tree u_hit_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eq_i       (cell_eq),
    .group_hit_o(group_hit)
  );

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CAP_COUNT)
    else $error("key count exceeds capacity");

  // A sorted, duplicate-free row matches the key in at most one cell.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_eq))
    else $error("key matched in more than one cell");

  // A refused add only happens on a miss with the set full.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_reject_o) |-> (!found_o && occupancy_o == CAP_COUNT))
    else $error("reject flagged without a full set or on a hit");

  // The less-than flags form a prefix of the row, as the row is sorted.
  a_lt_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_lt >> 1) & ~cell_lt) == '0)
    else $error("less-than flags are not a prefix of the row");

endmodule
